// ===== sv/uvs_pkg.sv =====
// uvs_pkg: shared types, constants and helpers of the uv sphere tessellator
// no dependencies; imported by every module of the block but uvs_div_cell
`default_nettype none

package uvs_pkg;

    // defaults for the top level parameters
    localparam int MAX_DIVISIONS_DEF = 255;
    localparam int ANGLE_BITS_DEF    = 16;

    // sine approximation constants, Q30
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int          SIN_STEPS   = 5;
    // sine unit latency: offset map, square, three stages per step, product, round
    localparam int          SIN_LAT     = 2 + 3 * SIN_STEPS + 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_RINGS  = 2'd1,
        CFG_SLICES = 2'd2
    } t_cfg_reg;

    // partial sine state handed from one series step to the next
    typedef struct packed {
        logic [31:0] x2;
        logic [30:0] x;
        logic        neg;
        logic [30:0] b;
    } t_sin_pipe;

    // per request side data carried alongside the arithmetic
    typedef struct packed {
        logic        vertex_valid;
        logic        quad_valid;
        logic [15:0] corner_top;
        logic [15:0] corner_bottom;
    } t_side;

    // divisors of the nested series, innermost first
    function automatic int sin_div(input int idx);
        int k;
        k = 6;
        case (idx)
            0:       k = 110;
            1:       k = 72;
            2:       k = 42;
            3:       k = 20;
            default: k = 6;
        endcase
        return k;
    endfunction

    // signed product shifted right by 14, round to nearest, ties away from zero
    function automatic logic signed [19:0] rnd_shift14(input logic signed [33:0] p);
        logic [33:0] mag;
        logic [33:0] r;
        mag = p[33] ? 34'(-p) : 34'(p);
        r   = (mag + 34'd8192) >> 14;
        return p[33] ? -$signed(r[19:0]) : $signed(r[19:0]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/uvs_div_cell.sv =====
// uvs_div_cell: one restoring division step, one quotient bit per cycle
// depends on nothing; chained by the top level to form a pipelined divider
`default_nettype none

module uvs_div_cell #(
    parameter int QUOT_BITS = 17
) (
    input  wire logic                 i_clk,
    input  wire logic [8:0]           i_rem,
    input  wire logic [QUOT_BITS-1:0] i_quo,
    input  wire logic [8:0]           i_div,
    output logic      [8:0]           o_rem,
    output logic      [QUOT_BITS-1:0] o_quo
);

    logic [9:0] trial;
    logic       ge;
    logic [9:0] diff;
    logic [8:0] n_rem;
    logic [QUOT_BITS-1:0] n_quo;

    assign trial = {i_rem, i_quo[QUOT_BITS-1]};
    assign ge    = trial >= {1'b0, i_div};
    assign diff  = trial - {1'b0, i_div};
    assign n_rem = ge ? diff[8:0] : trial[8:0];
    assign n_quo = {i_quo[QUOT_BITS-2:0], ge};

    always_ff @(posedge i_clk) begin
        o_rem <= n_rem;
        o_quo <= n_quo;
    end

endmodule

`default_nettype wire

// ===== sv/uvs_sin_cell.sv =====
// uvs_sin_cell: one step of the nested sine series, b = 1 - (x2*b)/K
// depends on uvs_pkg; three register stages
`default_nettype none

module uvs_sin_cell
    import uvs_pkg::*;
#(
    parameter int K = 6
) (
    input  wire logic      i_clk,
    input  wire t_sin_pipe i_p,
    output t_sin_pipe      o_p
);

    localparam logic [31:0] KV    = 32'(K);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

    t_sin_pipe   r_pa;
    t_sin_pipe   r_pb;
    logic [31:0] r_t;
    logic [31:0] r_t2;
    logic [31:0] r_q0;

    logic [62:0] prod;
    logic [63:0] mp;
    logic [31:0] qk;
    logic [31:0] rem;
    logic [31:0] q;

    assign prod = 63'(i_p.x2) * 63'(i_p.b);
    assign mp   = 64'(r_t) * 64'(RECIP);
    // reciprocal estimate is low by at most one
    assign qk   = r_q0 * KV;
    assign rem  = r_t2 - qk;
    assign q    = r_q0 + 32'(rem >= KV);

    always_ff @(posedge i_clk) begin
        r_t  <= prod[61:30];
        r_pa <= i_p;
        r_q0 <= mp[63:32];
        r_t2 <= r_t;
        r_pb <= r_pa;
        o_p.x2  <= r_pb.x2;
        o_p.x   <= r_pb.x;
        o_p.neg <= r_pb.neg;
        o_p.b   <= Q30_ONE - q[30:0];
    end

endmodule

`default_nettype wire

// ===== sv/uvs_sine.sv =====
// uvs_sine: pipelined sine of a phase, full turn = 2^ANGLE_BITS, Q1.14 out
// depends on uvs_pkg and uvs_sin_cell
`default_nettype none

module uvs_sine
    import uvs_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic [ANGLE_BITS-1:0] i_phase,
    output logic signed [15:0]         o_sin
);

    localparam int RW = ANGLE_BITS - 1;
    localparam int PW = ANGLE_BITS + 31;
    localparam logic [RW-1:0] QUARTER = RW'(1 << (ANGLE_BITS - 2));
    localparam logic [PW-1:0] X_RND   = PW'(1 << (ANGLE_BITS - 3));

    logic [1:0]    quad;
    logic [RW-1:0] off;
    logic [PW-1:0] xprod;
    logic [61:0]   sq;
    logic [61:0]   sprod;
    logic [31:0]   rnd;
    logic [15:0]   mag;

    logic [30:0] r_x1;
    logic        r_neg1;
    logic [30:0] r_s;
    logic        r_negf;

    t_sin_pipe r_p0;
    t_sin_pipe w_p [SIN_STEPS+1];

    // fold into the first quadrant
    assign quad  = i_phase[ANGLE_BITS-1 -: 2];
    assign off   = quad[0] ? QUARTER - RW'(i_phase[ANGLE_BITS-3:0])
                           : RW'(i_phase[ANGLE_BITS-3:0]);
    assign xprod = PW'(off) * PW'(HALF_PI_Q30) + X_RND;
    assign sq    = 62'(r_x1) * 62'(r_x1);

    always_ff @(posedge i_clk) begin
        r_x1   <= xprod[ANGLE_BITS+28:ANGLE_BITS-2];
        r_neg1 <= quad[1];
        r_p0.x2  <= sq[61:30];
        r_p0.x   <= r_x1;
        r_p0.neg <= r_neg1;
        r_p0.b   <= Q30_ONE;
    end

    assign w_p[0] = r_p0;

    for (genvar k = 0; k < SIN_STEPS; k++) begin : g_step
        uvs_sin_cell #(
            .K(sin_div(k))
        ) u_step (
            .i_clk (i_clk),
            .i_p   (w_p[k]),
            .o_p   (w_p[k+1])
        );
    end

    assign sprod = 62'(w_p[SIN_STEPS].x) * 62'(w_p[SIN_STEPS].b);
    assign rnd   = 32'(r_s) + 32'd32768;
    assign mag   = (rnd[31:16] > 16'd16384) ? 16'd16384 : rnd[31:16];

    always_ff @(posedge i_clk) begin
        r_s    <= sprod[60:30];
        r_negf <= w_p[SIN_STEPS].neg;
        o_sin  <= r_negf ? -$signed(mag) : $signed(mag);
    end

endmodule

`default_nettype wire

// ===== sv/uv_sphere_tessellator.sv =====
// uv_sphere_tessellator: top level, turns grid points into sphere vertices
// depends on uvs_pkg, uvs_div_cell, uvs_sine
`default_nettype none

// usage
//   request channel: drive i_ring_index / i_slice_index with i_start high for
//   one cycle per grid point; o_busy stays low, so a request is taken on every
//   cycle that i_start is high, back to back
//   result channel: o_strobe is high for exactly one cycle with the vertex on
//   the o_ ports; results come out in request order; the receiver cannot
//   stall, so it must take every result on its strobe cycle
//   config: i_cfg_we writes radius, ring count or slice count at once;
//   only write while no request is in flight
//   request to strobe: input register, divider cell chain, sine step
//   pipeline, normal and position stages, result register
//   throughput: one request per cycle, every stage is fully pipelined
//   reset: clears the strobe pipeline and loads radius 1.0, 16 rings and
//   16 slices; requests in flight at reset are dropped
//   out of range points give o_vertex_valid low and all other fields zero

module uv_sphere_tessellator
    import uvs_pkg::*;
#(
    parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [7:0]         i_ring_index,
    input  wire logic [7:0]         i_slice_index,
    // config write port
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    // result channel
    output logic                    o_strobe,
    output logic                    o_vertex_valid,
    output logic signed [16:0]      o_pos_x,
    output logic signed [16:0]      o_pos_y,
    output logic signed [16:0]      o_pos_z,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y,
    output logic signed [15:0]      o_normal_z,
    output logic [16:0]             o_tex_u,
    output logic [16:0]             o_tex_v,
    output logic                    o_quad_valid,
    output logic [15:0]             o_corner_top,
    output logic [15:0]             o_corner_bottom
);

    // quotient bits per divider, enough for every phase and texture coordinate
    localparam int QB       = (ANGLE_BITS + 1 > 17) ? ANGLE_BITS + 1 : 17;
    localparam int NW       = QB + 9;
    localparam int SIDE_DLY = QB + SIN_LAT + 4;
    localparam int TEX_DLY  = SIN_LAT + 3;
    localparam int LANES    = 4;
    // divider lanes
    localparam int L_PHI   = 0;
    localparam int L_THETA = 1;
    localparam int L_U     = 2;
    localparam int L_V     = 3;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    // config registers
    logic [15:0] r_radius;
    logic [7:0]  r_rings;
    logic [7:0]  r_slices;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd256;
            r_rings  <= 8'd16;
            r_slices <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_RADIUS: r_radius <= i_cfg_data;
                CFG_RINGS:  r_rings  <= i_cfg_data[7:0];
                CFG_SLICES: r_slices <= i_cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // counts saturate at the division limit
    logic [7:0] rc;
    logic [7:0] sc;
    logic [8:0] div_r;
    logic [8:0] div_s;

    assign rc    = (r_rings  > 8'(MAX_DIVISIONS)) ? 8'(MAX_DIVISIONS) : r_rings;
    assign sc    = (r_slices > 8'(MAX_DIVISIONS)) ? 8'(MAX_DIVISIONS) : r_slices;
    assign div_r = {rc, 1'b0};
    assign div_s = {sc, 1'b0};

    assign o_busy = 1'b0;

    // input stage: range checks, quad corners, rounded divider numerators
    logic          vvalid;
    logic          qvalid;
    logic [16:0]   corner_a;
    logic [15:0]   corner_b;
    logic [NW-1:0] num [LANES];
    logic [8:0]    lane_div [LANES];

    assign vvalid   = (rc != 8'd0) && (sc != 8'd0) &&
                      (i_ring_index <= rc) && (i_slice_index <= sc);
    assign qvalid   = vvalid && (i_ring_index < rc) && (i_slice_index < sc);
    assign corner_a = 17'(i_ring_index) * (17'(sc) + 17'd1) + 17'(i_slice_index);
    assign corner_b = corner_a[15:0] + 16'(sc) + 16'd1;

    assign num[L_PHI]   = (NW'(i_ring_index)  << ANGLE_BITS)       + NW'(rc);
    assign num[L_THETA] = (NW'(i_slice_index) << (ANGLE_BITS + 1)) + NW'(sc);
    assign num[L_U]     = (NW'(i_slice_index) << 17)               + NW'(sc);
    assign num[L_V]     = (NW'(i_ring_index)  << 17)               + NW'(rc);

    assign lane_div[L_PHI]   = div_r;
    assign lane_div[L_THETA] = div_s;
    assign lane_div[L_U]     = div_s;
    assign lane_div[L_V]     = div_r;

    logic [SIDE_DLY-1:0] r_stb;
    t_side               r_sd [SIDE_DLY];
    logic [8:0]          w_rem [LANES][QB+1];
    logic [QB-1:0]       w_quo [LANES][QB+1];
    logic [8:0]          r_rem0 [LANES];
    logic [QB-1:0]       r_quo0 [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= '0;
        end else begin
            r_stb <= {r_stb[SIDE_DLY-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0].vertex_valid  <= vvalid;
        r_sd[0].quad_valid    <= qvalid;
        r_sd[0].corner_top    <= qvalid ? corner_a[15:0] : 16'd0;
        r_sd[0].corner_bottom <= qvalid ? corner_b : 16'd0;
        for (int s = 1; s < SIDE_DLY; s++) begin
            r_sd[s] <= r_sd[s-1];
        end
        for (int l = 0; l < LANES; l++) begin
            r_rem0[l] <= num[l][NW-1:QB];
            r_quo0[l] <= num[l][QB-1:0];
        end
    end

    // divider chains, one quotient bit per cell
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_rem[l][0] = r_rem0[l];
        assign w_quo[l][0] = r_quo0[l];
        for (genvar c = 0; c < QB; c++) begin : g_cell
            uvs_div_cell #(
                .QUOT_BITS(QB)
            ) u_cell (
                .i_clk (i_clk),
                .i_rem (w_rem[l][c]),
                .i_quo (w_quo[l][c]),
                .i_div (lane_div[l]),
                .o_rem (w_rem[l][c+1]),
                .o_quo (w_quo[l][c+1])
            );
        end
    end

    // phases: polar angle is a half turn at most, azimuth wraps at a full turn
    logic [ANGLE_BITS-1:0] ph_phi;
    logic [ANGLE_BITS-1:0] ph_theta;
    logic [ANGLE_BITS-1:0] ph_phi_c;
    logic [ANGLE_BITS-1:0] ph_theta_c;

    assign ph_phi     = w_quo[L_PHI][QB][ANGLE_BITS-1:0];
    assign ph_theta   = w_quo[L_THETA][QB][ANGLE_BITS-1:0];
    assign ph_phi_c   = ph_phi + QUARTER;
    assign ph_theta_c = ph_theta + QUARTER;

    logic signed [15:0] sin_phi;
    logic signed [15:0] cos_phi;
    logic signed [15:0] sin_theta;
    logic signed [15:0] cos_theta;

    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_phi (
        .i_clk (i_clk), .i_phase (ph_phi), .o_sin (sin_phi)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_phi (
        .i_clk (i_clk), .i_phase (ph_phi_c), .o_sin (cos_phi)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_theta (
        .i_clk (i_clk), .i_phase (ph_theta), .o_sin (sin_theta)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_theta (
        .i_clk (i_clk), .i_phase (ph_theta_c), .o_sin (cos_theta)
    );

    // texture coordinates wait for the sine and scaling stages
    logic [16:0] r_tex_u [TEX_DLY];
    logic [16:0] r_tex_v [TEX_DLY];

    always_ff @(posedge i_clk) begin
        r_tex_u[0] <= w_quo[L_U][QB][16:0];
        r_tex_v[0] <= w_quo[L_V][QB][16:0];
        for (int s = 1; s < TEX_DLY; s++) begin
            r_tex_u[s] <= r_tex_u[s-1];
            r_tex_v[s] <= r_tex_v[s-1];
        end
    end

    // normal: sin phi times cos / sin theta, then round back to Q1.14
    logic signed [31:0] r_pnx;
    logic signed [31:0] r_pnz;
    logic signed [15:0] r_ny1;
    logic signed [15:0] r_nx2;
    logic signed [15:0] r_ny2;
    logic signed [15:0] r_nz2;
    logic signed [19:0] rnd_nx;
    logic signed [19:0] rnd_nz;

    assign rnd_nx = rnd_shift14(34'(r_pnx));
    assign rnd_nz = rnd_shift14(34'(r_pnz));

    always_ff @(posedge i_clk) begin
        r_pnx <= sin_phi * cos_theta;
        r_pnz <= sin_phi * sin_theta;
        r_ny1 <= cos_phi;
        r_nx2 <= rnd_nx[15:0];
        r_nz2 <= rnd_nz[15:0];
        r_ny2 <= r_ny1;
    end

    // position: normal times Q8.8 radius
    logic signed [16:0] rad_s;
    logic signed [32:0] r_ppx;
    logic signed [32:0] r_ppy;
    logic signed [32:0] r_ppz;
    logic signed [15:0] r_nx3;
    logic signed [15:0] r_ny3;
    logic signed [15:0] r_nz3;
    logic signed [19:0] rnd_px;
    logic signed [19:0] rnd_py;
    logic signed [19:0] rnd_pz;

    assign rad_s  = $signed({1'b0, r_radius});
    assign rnd_px = rnd_shift14(34'(r_ppx));
    assign rnd_py = rnd_shift14(34'(r_ppy));
    assign rnd_pz = rnd_shift14(34'(r_ppz));

    always_ff @(posedge i_clk) begin
        r_ppx <= r_nx2 * rad_s;
        r_ppy <= r_ny2 * rad_s;
        r_ppz <= r_nz2 * rad_s;
        r_nx3 <= r_nx2;
        r_ny3 <= r_ny2;
        r_nz3 <= r_nz2;
    end

    // result register, everything zero for an out of range point
    t_side side_o;
    logic  vv;

    assign side_o = r_sd[SIDE_DLY-1];
    assign vv     = side_o.vertex_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_stb[SIDE_DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_vertex_valid  <= vv;
        o_pos_x         <= vv ? rnd_px[16:0] : 17'sd0;
        o_pos_y         <= vv ? rnd_py[16:0] : 17'sd0;
        o_pos_z         <= vv ? rnd_pz[16:0] : 17'sd0;
        o_normal_x      <= vv ? r_nx3 : 16'sd0;
        o_normal_y      <= vv ? r_ny3 : 16'sd0;
        o_normal_z      <= vv ? r_nz3 : 16'sd0;
        o_tex_u         <= vv ? r_tex_u[TEX_DLY-1] : 17'd0;
        o_tex_v         <= vv ? r_tex_v[TEX_DLY-1] : 17'd0;
        o_quad_valid    <= side_o.quad_valid;
        o_corner_top    <= side_o.corner_top;
        o_corner_bottom <= side_o.corner_bottom;
    end

endmodule

`default_nettype wire
